// ===== src/sbie_pkg.sv =====
package sbie_pkg;

  // Fixed architectural sizes
  localparam int REG_COUNT = 16;
  localparam int REG_AW    = 4;
  localparam int ADDR_W    = 8;

  typedef enum logic [1:0] {
    ACT_EXEC     = 2'd0,
    ACT_LOAD_REG = 2'd1,
    ACT_LOAD_MEM = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_INC  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_NOT  = 4'd7,
    OP_SLLI = 4'd8,
    OP_SRLI = 4'd9,
    OP_LI   = 4'd10,
    OP_LD   = 4'd11,
    OP_ST   = 4'd12,
    OP_JMP  = 4'd13,
    OP_BEQZ = 4'd14,
    OP_HLT  = 4'd15
  } opcode_t;

  // Where an operand of the execute stage comes from
  typedef enum logic [1:0] {
    SRC_RF   = 2'd0,
    SRC_FWD  = 2'd1,
    SRC_LOAD = 2'd2
  } src_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] instruction;
    logic [7:0]  load_index;
    logic [7:0]  load_value;
  } item_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       halted;
    logic       branch_taken;
    logic       reg_write;
    logic [3:0] reg_index;
    logic [7:0] reg_value;
    logic       mem_write;
    logic [7:0] mem_addr;
    logic [7:0] mem_value;
  } result_t;

  // Side effects of one executed item
  typedef struct packed {
    logic wr;
    logic is_ld;
    logic mem_we;
  } ctl_t;

  // Opcodes whose second read port takes rd instead of rs2
  function automatic logic reads_rd(logic [3:0] op);
    logic r;
    unique case (op) inside
      OP_INC, OP_ST, OP_BEQZ: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sbie_regfile.sv =====
module sbie_regfile #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       re,
  input  logic [sbie_pkg::REG_AW-1:0] ra,
  input  logic [sbie_pkg::REG_AW-1:0] rb,
  output logic [DATA_WIDTH-1:0]      rdata_a,
  output logic [DATA_WIDTH-1:0]      rdata_b,
  input  logic                       we,
  input  logic [sbie_pkg::REG_AW-1:0] wa,
  input  logic [DATA_WIDTH-1:0]      wd
);
  import sbie_pkg::*;

  logic [DATA_WIDTH-1:0] regs [REG_COUNT];

  // Write port; reset clears every register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else if (we) begin
      regs[wa] <= wd;
    end
  end

  // Two registered read ports, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= regs[ra];
      rdata_b <= regs[rb];
    end
  end

endmodule

// ===== src/sbie_dmem.sv =====
module sbie_dmem #(
  parameter int DMEM_DEPTH = 256,
  parameter int DATA_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        re,
  input  logic [sbie_pkg::ADDR_W-1:0] raddr,
  output logic [DATA_WIDTH-1:0]       rdata,
  input  logic                        we,
  input  logic [sbie_pkg::ADDR_W-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]       wdata
);
  import sbie_pkg::*;

  localparam int AW = $clog2(DMEM_DEPTH);
  localparam int RW = ADDR_W + 4;

  logic [DATA_WIDTH-1:0] mem [DMEM_DEPTH];
  logic [DMEM_DEPTH-1:0] vld;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  rvld_q;
  logic [AW-1:0]         ridx;
  logic [AW-1:0]         widx;

  // Fold a byte address onto the depth; sixteen times the depth covers 8 bits
  function automatic logic [AW-1:0] fold(logic [ADDR_W-1:0] addr);
    logic [RW-1:0] w;
    w = RW'(addr);
    for (int k = 3; k >= 0; k--) begin
      if (w >= RW'(DMEM_DEPTH << k)) begin
        w = w - RW'(DMEM_DEPTH << k);
      end
    end
    return w[AW-1:0];
  endfunction

  assign ridx = fold(raddr);
  assign widx = fold(waddr);

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[ridx];
    end
  end

  // Per-word written marks; an unwritten word reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[widx] <= 1'b1;
      end
      if (re) begin
        rvld_q <= vld[ridx];
      end
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

// ===== src/sbie_exec.sv =====
module sbie_exec #(
  parameter int DATA_WIDTH = 8
) (
  input  sbie_pkg::item_t              item,
  input  logic [DATA_WIDTH-1:0]        a,
  input  logic [DATA_WIDTH-1:0]        b,
  input  logic [sbie_pkg::ADDR_W-1:0]  pc,
  input  logic                         halt,
  output sbie_pkg::ctl_t               ctl,
  output logic [sbie_pkg::REG_AW-1:0]  widx,
  output logic [DATA_WIDTH-1:0]        wval,
  output logic [sbie_pkg::ADDR_W-1:0]  maddr,
  output logic [DATA_WIDTH-1:0]        mdata,
  output sbie_pkg::result_t            res
);
  import sbie_pkg::*;

  // Decode and execute one item
  always_comb begin
    logic [3:0]        rd;
    logic [3:0]        rs1;
    logic [3:0]        rs2;
    opcode_t           op;
    logic [7:0]        off;
    logic [ADDR_W-1:0] npc;
    logic              halt_n;
    logic              taken;
    rd     = item.instruction[11:8];
    rs1    = item.instruction[7:4];
    rs2    = item.instruction[3:0];
    op     = opcode_t'(item.instruction[15:12]);
    off    = '0;
    ctl    = '0;
    widx   = '0;
    wval   = '0;
    maddr  = '0;
    mdata  = '0;
    npc    = pc;
    halt_n = halt;
    taken  = 1'b0;
    unique case (item.action)
      ACT_LOAD_REG: begin
        if (item.load_index < 8'(REG_COUNT)) begin
          ctl.wr = 1'b1;
          widx   = item.load_index[REG_AW-1:0];
          wval   = DATA_WIDTH'(item.load_value);
        end
      end
      ACT_LOAD_MEM: begin
        ctl.mem_we = 1'b1;
        maddr      = item.load_index;
        mdata      = DATA_WIDTH'(item.load_value);
      end
      ACT_EXEC: begin
        if (!halt) begin
          npc  = pc + 8'd2;
          widx = rd;
          unique case (op)
            OP_ADD:  begin ctl.wr = 1'b1; wval = a + b; end
            OP_SUB:  begin ctl.wr = 1'b1; wval = a - b; end
            OP_MUL:  begin ctl.wr = 1'b1; wval = a * b; end
            OP_INC:  begin ctl.wr = 1'b1; wval = b + 1'b1; end
            OP_AND:  begin ctl.wr = 1'b1; wval = a & b; end
            OP_OR:   begin ctl.wr = 1'b1; wval = a | b; end
            OP_XOR:  begin ctl.wr = 1'b1; wval = a ^ b; end
            OP_NOT:  begin ctl.wr = 1'b1; wval = ~a; end
            OP_SLLI: begin ctl.wr = 1'b1; wval = a << rs2; end
            OP_SRLI: begin ctl.wr = 1'b1; wval = a >> rs2; end
            OP_LI:   begin ctl.wr = 1'b1; wval = DATA_WIDTH'(item.instruction[7:0]); end
            OP_LD: begin
              ctl.wr    = 1'b1;
              ctl.is_ld = 1'b1;
              maddr     = a[7:0] + {4'b0, rs2};
            end
            OP_ST: begin
              ctl.mem_we = 1'b1;
              maddr      = a[7:0] + {4'b0, rs2};
              mdata      = b;
            end
            OP_JMP: begin
              off   = item.instruction[11:4];
              npc   = pc + 8'd2 + {off[6:0], 1'b0};
              taken = 1'b1;
            end
            OP_BEQZ: begin
              off = item.instruction[7:0];
              if (b == '0) begin
                npc   = pc + 8'd2 + {off[6:0], 1'b0};
                taken = 1'b1;
              end
            end
            OP_HLT:  halt_n = 1'b1;
          endcase
          if (!ctl.wr) begin
            widx = '0;
          end
        end
      end
      default: ;
    endcase
    // Drop the register and memory fields of a step that wrote nothing
    res.next_pc      = npc;
    res.halted       = halt_n;
    res.branch_taken = taken;
    res.reg_write    = ctl.wr;
    res.reg_index    = widx;
    res.reg_value    = ctl.wr ? wval[7:0] : 8'd0;
    res.mem_write    = ctl.mem_we;
    res.mem_addr     = ctl.mem_we ? maddr : 8'd0;
    res.mem_value    = ctl.mem_we ? mdata[7:0] : 8'd0;
  end

endmodule

// ===== src/sixteen_bit_isa_executor.sv =====
// Executes one instruction or one register/memory preload per beat, with a
// sustained rate of one item per clock while the output is not stalled. The
// item first reads the register file (both read ports registered), then
// executes and reads or writes the data memory (registered read), then writes
// the register file as its result is loaded into the output register.
// Register values are forwarded from the two later stages, so back-to-back
// dependent instructions, loads included, never bubble; the only stall is
// result_ready held low, which freezes the whole pipeline. After reset the
// register file, data memory, PC and halt flag are zero and the block takes
// items at once.
module sixteen_bit_isa_executor #(
  parameter int DMEM_DEPTH = 256,
  parameter int DATA_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sbie_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output sbie_pkg::result_t result
);
  import sbie_pkg::*;

  logic adv;

  // Read stage
  logic                  s1_valid;
  item_t                 s1_item;
  src_t                  s1_a_sel;
  src_t                  s1_b_sel;
  logic [DATA_WIDTH-1:0] s1_a_fwd;
  logic [DATA_WIDTH-1:0] s1_b_fwd;
  src_t                  s1_a_sel_next;
  src_t                  s1_b_sel_next;
  logic [DATA_WIDTH-1:0] s1_a_fwd_next;
  logic [DATA_WIDTH-1:0] s1_b_fwd_next;
  logic [REG_AW-1:0]     ra;
  logic [REG_AW-1:0]     rb;
  logic [DATA_WIDTH-1:0] rf_a;
  logic [DATA_WIDTH-1:0] rf_b;
  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;

  // Execute results
  ctl_t                  s1_ctl;
  logic [REG_AW-1:0]     s1_widx;
  logic [DATA_WIDTH-1:0] s1_wval;
  logic [ADDR_W-1:0]     s1_maddr;
  logic [DATA_WIDTH-1:0] s1_mdata;
  result_t               s1_res;

  // Memory stage
  logic                  s2_valid;
  ctl_t                  s2_ctl;
  logic [REG_AW-1:0]     s2_widx;
  logic [DATA_WIDTH-1:0] s2_wval;
  result_t               s2_res;
  result_t               s2_res_eff;
  logic [DATA_WIDTH-1:0] ld_data;
  logic [DATA_WIDTH-1:0] s2_wval_eff;

  // Architectural state
  logic [ADDR_W-1:0] pc;
  logic              halt;

  // Freeze everything while a finished result waits
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  assign ra = item.instruction[7:4];
  assign rb = reads_rd(item.instruction[15:12]) ? item.instruction[11:8]
                                                : item.instruction[3:0];

  sbie_regfile #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .re     (adv),
    .ra     (ra),
    .rb     (rb),
    .rdata_a(rf_a),
    .rdata_b(rf_b),
    .we     (adv && s2_valid && s2_ctl.wr),
    .wa     (s2_widx),
    .wd     (s2_wval_eff)
  );

  assign s2_wval_eff = s2_ctl.is_ld ? ld_data : s2_wval;

  // Splice the loaded word into the finished result
  always_comb begin
    s2_res_eff = s2_res;
    if (s2_ctl.is_ld) begin
      s2_res_eff.reg_value = ld_data[7:0];
    end
  end

  // Pick operand sources for the incoming beat: newest writer wins
  always_comb begin
    s1_a_sel_next = SRC_RF;
    s1_a_fwd_next = s2_wval_eff;
    s1_b_sel_next = SRC_RF;
    s1_b_fwd_next = s2_wval_eff;
    if (s1_valid && s1_ctl.wr && s1_widx == ra) begin
      s1_a_sel_next = s1_ctl.is_ld ? SRC_LOAD : SRC_FWD;
      s1_a_fwd_next = s1_wval;
    end else if (s2_valid && s2_ctl.wr && s2_widx == ra) begin
      s1_a_sel_next = SRC_FWD;
    end
    if (s1_valid && s1_ctl.wr && s1_widx == rb) begin
      s1_b_sel_next = s1_ctl.is_ld ? SRC_LOAD : SRC_FWD;
      s1_b_fwd_next = s1_wval;
    end else if (s2_valid && s2_ctl.wr && s2_widx == rb) begin
      s1_b_sel_next = SRC_FWD;
    end
  end

  // Resolve operands; a pending load is the item just ahead
  always_comb begin
    case (s1_a_sel)
      SRC_FWD:  op_a = s1_a_fwd;
      SRC_LOAD: op_a = ld_data;
      default:  op_a = rf_a;
    endcase
    case (s1_b_sel)
      SRC_FWD:  op_b = s1_b_fwd;
      SRC_LOAD: op_b = ld_data;
      default:  op_b = rf_b;
    endcase
  end

  sbie_exec #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_exec (
    .item (s1_item),
    .a    (op_a),
    .b    (op_b),
    .pc   (pc),
    .halt (halt),
    .ctl  (s1_ctl),
    .widx (s1_widx),
    .wval (s1_wval),
    .maddr(s1_maddr),
    .mdata(s1_mdata),
    .res  (s1_res)
  );

  sbie_dmem #(
    .DMEM_DEPTH(DMEM_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dmem (
    .clk  (clk),
    .rst  (rst),
    .re   (adv && s1_valid),
    .raddr(s1_maddr),
    .rdata(ld_data),
    .we   (adv && s1_valid && s1_ctl.mem_we),
    .waddr(s1_maddr),
    .wdata(s1_mdata)
  );

  // Control: stage valids, PC and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      pc           <= '0;
      halt         <= 1'b0;
    end else if (adv) begin
      s1_valid     <= item_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
      if (s1_valid) begin
        pc   <= s1_res.next_pc;
        halt <= s1_res.halted;
      end
    end
  end

  // Payload: advance all stages together
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item  <= item;
      s1_a_sel <= s1_a_sel_next;
      s1_b_sel <= s1_b_sel_next;
      s1_a_fwd <= s1_a_fwd_next;
      s1_b_fwd <= s1_b_fwd_next;
      s2_ctl   <= s1_ctl;
      s2_widx  <= s1_widx;
      s2_wval  <= s1_wval;
      s2_res   <= s1_res;
      result   <= s2_res_eff;
    end
  end

  // Once set, the halt flag stays until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halt |=> halt)
    else $error("halt flag cleared without reset");

  // A pending load operand always has its load one stage ahead
  a_load_fwd_a: assert property (@(posedge clk) disable iff (rst)
      s1_valid && s1_a_sel == SRC_LOAD |-> s2_valid && s2_ctl.is_ld)
    else $error("operand a waits on a load that is not in flight");

  a_load_fwd_b: assert property (@(posedge clk) disable iff (rst)
      s1_valid && s1_b_sel == SRC_LOAD |-> s2_valid && s2_ctl.is_ld)
    else $error("operand b waits on a load that is not in flight");

  // One step never writes both a register and memory
  a_one_write: assert property (@(posedge clk) disable iff (rst)
      result_valid && result.mem_write |-> !result.reg_write)
    else $error("result reports both register and memory write");

  // A jump or branch can only execute while running
  a_taken_running: assert property (@(posedge clk) disable iff (rst)
      result_valid && result.branch_taken |-> !result.halted)
    else $error("branch taken reported with halt set");

endmodule

// ===== dv/tb_sixteen_bit_isa_executor.sv =====
module tb_sixteen_bit_isa_executor;
  import sbie_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // Architectural state of the predicted machine
  logic [7:0] arch_regs [REG_COUNT];
  logic [7:0] arch_mem [256];
  logic [7:0] arch_pc;
  logic       arch_halted;

  result_t pending_results [$];
  int      error_count;
  int      quiet_cycles;
  int      send_idle_pct;
  int      recv_stall_pct;

  typedef struct {
    bit      tail;
    item_t   beat;
    bit      typed;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  sixteen_bit_isa_executor uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] encode(opcode_t op, logic [3:0] rd, logic [3:0] rs1,
                                         logic [3:0] rs2);
    return {op, rd, rs1, rs2};
  endfunction

  function automatic result_t mk_result(logic [7:0] pc, logic halted, logic taken,
                                        logic rw, logic [3:0] ri, logic [7:0] rv,
                                        logic mw, logic [7:0] ma, logic [7:0] mv);
    result_t r;
    r.next_pc      = pc;
    r.halted       = halted;
    r.branch_taken = taken;
    r.reg_write    = rw;
    r.reg_index    = ri;
    r.reg_value    = rv;
    r.mem_write    = mw;
    r.mem_addr     = ma;
    r.mem_value    = mv;
    return r;
  endfunction

  // Apply one beat to the architectural state and return the result it yields
  function automatic result_t retire_item(item_t it);
    result_t    r;
    logic [3:0] rd;
    logic [3:0] rs1;
    logic [3:0] rs2;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] v;
    logic [7:0] npc;
    logic [7:0] addr;
    logic       wr;
    r   = '0;
    rd  = it.instruction[11:8];
    rs1 = it.instruction[7:4];
    rs2 = it.instruction[3:0];
    case (it.action)
      ACT_LOAD_REG: begin
        if (it.load_index < REG_COUNT) begin
          arch_regs[it.load_index[3:0]] = it.load_value;
          r.reg_write = 1'b1;
          r.reg_index = it.load_index[3:0];
          r.reg_value = it.load_value;
        end
      end
      ACT_LOAD_MEM: begin
        arch_mem[it.load_index] = it.load_value;
        r.mem_write = 1'b1;
        r.mem_addr  = it.load_index;
        r.mem_value = it.load_value;
      end
      ACT_EXEC: begin
        if (!arch_halted) begin
          npc = arch_pc + 8'd2;
          a   = arch_regs[rs1];
          b   = arch_regs[rs2];
          v   = '0;
          wr  = 1'b1;
          case (opcode_t'(it.instruction[15:12]))
            OP_ADD:  v = a + b;
            OP_SUB:  v = a - b;
            OP_MUL:  v = a * b;
            OP_INC:  v = arch_regs[rd] + 8'd1;
            OP_AND:  v = a & b;
            OP_OR:   v = a | b;
            OP_XOR:  v = a ^ b;
            OP_NOT:  v = ~a;
            OP_SLLI: v = a << rs2;
            OP_SRLI: v = a >> rs2;
            OP_LI:   v = it.instruction[7:0];
            OP_LD:   v = arch_mem[a + {4'd0, rs2}];
            OP_ST: begin
              wr   = 1'b0;
              addr = a + {4'd0, rs2};
              arch_mem[addr] = arch_regs[rd];
              r.mem_write = 1'b1;
              r.mem_addr  = addr;
              r.mem_value = arch_regs[rd];
            end
            OP_JMP: begin
              wr  = 1'b0;
              npc = arch_pc + 8'd2 + {it.instruction[10:4], 1'b0};
              r.branch_taken = 1'b1;
            end
            OP_BEQZ: begin
              wr = 1'b0;
              if (arch_regs[rd] == 8'd0) begin
                npc = arch_pc + 8'd2 + {it.instruction[6:0], 1'b0};
                r.branch_taken = 1'b1;
              end
            end
            default: begin
              wr = 1'b0;
              arch_halted = 1'b1;
            end
          endcase
          if (wr) begin
            arch_regs[rd] = v;
            r.reg_write = 1'b1;
            r.reg_index = rd;
            r.reg_value = v;
          end
          arch_pc = npc;
        end
      end
      default: ;
    endcase
    r.next_pc = arch_pc;
    r.halted  = arch_halted;
    return r;
  endfunction

  // Random beat: mostly instructions, some preloads, a few unknown actions
  function automatic item_t random_item();
    item_t   it;
    int      pick;
    int      zero_regs [$];
    opcode_t op;
    it.action      = ACT_EXEC;
    it.instruction = 16'($urandom);
    it.load_index  = 8'($urandom);
    it.load_value  = 8'($urandom);
    if ($urandom_range(0, 7) == 0) it.load_value = 8'd0;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.action = ACT_LOAD_REG;
      if ($urandom_range(0, 9) != 0) it.load_index[7:4] = 4'd0;
    end else if (pick < 24) begin
      it.action = ACT_LOAD_MEM;
    end else if (pick < 26) begin
      it.action = ACT_UNKNOWN;
    end else begin
      // keep halt out of the random stream so the machine stays live
      op = opcode_t'($urandom_range(0, 14));
      it.instruction[15:12] = op;
      if (op == OP_LI && $urandom_range(0, 7) == 0) it.instruction[7:0] = 8'd0;
      if (op == OP_BEQZ && $urandom_range(0, 1) == 1) begin
        foreach (arch_regs[i]) if (arch_regs[i] == 8'd0) zero_regs.push_back(i);
        if (zero_regs.size() != 0)
          it.instruction[11:8] = 4'(zero_regs[$urandom_range(0, zero_regs.size() - 1)]);
      end
    end
    return it;
  endfunction

  task automatic add_row(bit tail, logic [1:0] act, logic [15:0] ins, logic [7:0] idx,
                         logic [7:0] val, bit typed, result_t want);
    stim_row_t row;
    row.tail             = tail;
    row.beat.action      = act;
    row.beat.instruction = ins;
    row.beat.load_index  = idx;
    row.beat.load_value  = val;
    row.typed            = typed;
    row.want             = want;
    directed_rows.push_back(row);
  endtask

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("result beat with nothing outstanding: %p", got));
    end else begin
      want = pending_results.pop_front();
      compare_field("next_pc", 32'(got.next_pc), 32'(want.next_pc));
      compare_field("halted", 32'(got.halted), 32'(want.halted));
      compare_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
      compare_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
      compare_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
      compare_field("reg_value", 32'(got.reg_value), 32'(want.reg_value));
      compare_field("mem_write", 32'(got.mem_write), 32'(want.mem_write));
      compare_field("mem_addr", 32'(got.mem_addr), 32'(want.mem_addr));
      compare_field("mem_value", 32'(got.mem_value), 32'(want.mem_value));
    end
  endtask

  // Present one beat, hold it until accepted, then record its expected result
  task automatic drive_item(item_t it, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = retire_item(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receive side: random backpressure and checking
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (result_valid && result_ready) check_result(result);
    end
  end

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int ph;
    rst            <= 1'b1;
    item_valid     <= 1'b0;
    item           <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    arch_pc        = '0;
    arch_halted    = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;

    // Opening rows: reset state, extremes, ignored beats, every opcode but halt
    add_row(0, ACT_EXEC, encode(OP_ADD, 4'd1, 4'd0, 4'd0), 8'h00, 8'h00, 1,
            mk_result(8'd2, 0, 0, 1, 4'd1, 8'h00, 0, 8'h00, 8'h00));
    add_row(0, ACT_LOAD_REG, 16'h0000, 8'd15, 8'hFF, 1,
            mk_result(8'd2, 0, 0, 1, 4'd15, 8'hFF, 0, 8'h00, 8'h00));
    add_row(0, ACT_LOAD_REG, 16'hFFFF, 8'd16, 8'hAA, 1,
            mk_result(8'd2, 0, 0, 0, 4'd0, 8'h00, 0, 8'h00, 8'h00));
    add_row(0, ACT_LOAD_REG, 16'h0000, 8'hFF, 8'h55, 1,
            mk_result(8'd2, 0, 0, 0, 4'd0, 8'h00, 0, 8'h00, 8'h00));
    add_row(0, ACT_LOAD_MEM, 16'h0000, 8'hFF, 8'hFF, 1,
            mk_result(8'd2, 0, 0, 0, 4'd0, 8'h00, 1, 8'hFF, 8'hFF));
    add_row(0, ACT_UNKNOWN, 16'hFFFF, 8'hFF, 8'hFF, 1,
            mk_result(8'd2, 0, 0, 0, 4'd0, 8'h00, 0, 8'h00, 8'h00));
    add_row(0, ACT_EXEC, encode(OP_LI, 4'd2, 4'h8, 4'h0), 8'h00, 8'h00, 1,
            mk_result(8'd4, 0, 0, 1, 4'd2, 8'h80, 0, 8'h00, 8'h00));
    add_row(0, ACT_LOAD_MEM, 16'h0000, 8'h00, 8'h80, 1,
            mk_result(8'd4, 0, 0, 0, 4'd0, 8'h00, 1, 8'h00, 8'h80));
    add_row(0, ACT_LOAD_REG, 16'h0000, 8'd3, 8'h01, 1,
            mk_result(8'd4, 0, 0, 1, 4'd3, 8'h01, 0, 8'h00, 8'h00));
    add_row(0, ACT_EXEC, encode(OP_ADD, 4'd4, 4'd15, 4'd3), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_SUB, 4'd5, 4'd0, 4'd3), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_MUL, 4'd6, 4'd15, 4'd15), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_INC, 4'd15, 4'd0, 4'd0), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_AND, 4'd7, 4'd2, 4'd5), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_OR, 4'd8, 4'd2, 4'd3), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_XOR, 4'd9, 4'd5, 4'd2), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_NOT, 4'd10, 4'd0, 4'd0), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_SLLI, 4'd11, 4'd10, 4'd15), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_SRLI, 4'd12, 4'd10, 4'd7), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_LD, 4'd13, 4'd10, 4'd0), 8'h00, 8'h00, 0, '0);
    // store address wraps past the top of memory
    add_row(0, ACT_EXEC, encode(OP_ST, 4'd2, 4'd10, 4'd15), 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, encode(OP_LD, 4'd14, 4'd10, 4'd15), 8'h00, 8'h00, 0, '0);
    // largest jump offset and one whose top bit is dropped, taken and untaken branches
    add_row(0, ACT_EXEC, {OP_JMP, 8'h7F, 4'h0}, 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, {OP_JMP, 8'h80, 4'h0}, 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, {OP_BEQZ, 4'd0, 8'hFF}, 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, {OP_BEQZ, 4'd3, 8'h01}, 8'h00, 8'h00, 0, '0);
    add_row(0, ACT_EXEC, {OP_BEQZ, 4'd15, 8'h80}, 8'h00, 8'h00, 0, '0);

    // Closing rows: halt, then everything that follows a halt
    add_row(1, ACT_EXEC, 16'hFFFF, 8'h00, 8'h00, 0, '0);
    add_row(1, ACT_EXEC, encode(OP_ADD, 4'd1, 4'd3, 4'd3), 8'h00, 8'h00, 0, '0);
    add_row(1, ACT_LOAD_REG, 16'h0000, 8'd5, 8'h33, 0, '0);
    add_row(1, ACT_LOAD_MEM, 16'h0000, 8'h10, 8'h44, 0, '0);
    add_row(1, ACT_EXEC, encode(OP_LD, 4'd6, 4'd0, 4'd0), 8'h00, 8'h00, 0, '0);
    add_row(1, ACT_UNKNOWN, 16'h0000, 8'h00, 8'h00, 0, '0);
    add_row(1, ACT_EXEC, encode(OP_HLT, 4'd0, 4'd0, 4'd0), 8'h00, 8'h00, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      if (!directed_rows[i].tail)
        drive_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic under each idling mix; drain fully between mixes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (ITEMS_PER_PHASE) drive_item(random_item(), 1'b0, '0);
      if (ph != 3) wait_for_results();
    end

    foreach (directed_rows[i])
      if (directed_rows[i].tail)
        drive_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sbie_pkg.sv
src/sbie_regfile.sv
src/sbie_dmem.sv
src/sbie_exec.sv
src/sixteen_bit_isa_executor.sv
dv/tb_sixteen_bit_isa_executor.sv
